// ===== rtl/lrudp_pkg.sv =====
// lrudp_pkg: shared types and constants of the lru demand paging engine
// depends on nothing; imported by every module of the block
package lrudp_pkg;

  localparam int ADDR_W      = 6;
  localparam int BYTE_W      = 8;
  localparam int FRAME_OUT_W = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic MODE_READ    = 1'b0;
  localparam logic MODE_WRITE   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAGE,
    S_HIT_FR,
    S_MISS_FR,
    S_MISS_VIC,
    S_MV_NEXT,
    S_MV_PREV,
    S_MV_TAIL,
    S_MV_SELF,
    S_DONE
  } state_t;

  typedef struct packed {
    logic byte_we;
    logic page_we;
    logic prev_we;
    logic next_we;
  } frame_we_t;

endpackage

// ===== rtl/lrudp_page_table.sv =====
// lrudp_page_table: per-page memory of present, dirty, frame and backing byte
// one write port, one registered read port; depends on lrudp_pkg
module lrudp_page_table
  import lrudp_pkg::*;
#(
  parameter int PAGES  = 32,
  parameter int FRAMES = 16,
  localparam int PW = $clog2(PAGES),
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic              clk,
  input  logic              init_en,
  input  logic [PW-1:0]     init_idx,
  input  logic              rd_en,
  input  logic [PW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [PW-1:0]     wr_addr,
  input  logic              wr_present,
  input  logic              wr_dirty,
  input  logic [FW-1:0]     wr_frame,
  input  logic [BYTE_W-1:0] wr_byte,
  output logic              rd_present,
  output logic              rd_dirty,
  output logic [FW-1:0]     rd_frame,
  output logic [BYTE_W-1:0] rd_byte
);

  localparam int WORD_W = 2 + FW + BYTE_W;

  logic [WORD_W-1:0] mem [PAGES];
  logic [WORD_W-1:0] rd_word_r;
  logic [WORD_W-1:0] init_word;
  logic              init_res;

  always_comb begin
    init_res  = int'(init_idx) < FRAMES;
    init_word = {init_res, 1'b0, (init_res ? init_idx[FW-1:0] : {FW{1'b0}}), {BYTE_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (init_en) begin
      mem[init_idx] <= init_word;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_present, wr_dirty, wr_frame, wr_byte};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign {rd_present, rd_dirty, rd_frame, rd_byte} = rd_word_r;

endmodule

// ===== rtl/lrudp_frame_table.sv =====
// lrudp_frame_table: per-frame memory of byte, owning page and lru list links
// field write enables, one registered read port; depends on lrudp_pkg
module lrudp_frame_table
  import lrudp_pkg::*;
#(
  parameter int PAGES  = 32,
  parameter int FRAMES = 16,
  localparam int PW = $clog2(PAGES),
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic              clk,
  input  logic              init_en,
  input  logic [FW-1:0]     init_idx,
  input  logic              rd_en,
  input  logic [FW-1:0]     rd_addr,
  input  frame_we_t         wr_en,
  input  logic [FW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_byte,
  input  logic [PW-1:0]     wr_page,
  input  logic [FW-1:0]     wr_prev,
  input  logic [FW-1:0]     wr_next,
  output logic [BYTE_W-1:0] rd_byte_r,
  output logic [PW-1:0]     rd_page_r,
  output logic [FW-1:0]     rd_prev_r,
  output logic [FW-1:0]     rd_next_r
);

  logic [BYTE_W-1:0] byte_mem [FRAMES];
  logic [PW-1:0]     page_mem [FRAMES];
  logic [FW-1:0]     prev_mem [FRAMES];
  logic [FW-1:0]     next_mem [FRAMES];

  logic [PW+FW-1:0] idx_ext;

  assign idx_ext = {{PW{1'b0}}, init_idx};

  always_ff @(posedge clk) begin
    if (init_en) begin
      byte_mem[init_idx] <= '0;
      page_mem[init_idx] <= idx_ext[PW-1:0];
      prev_mem[init_idx] <= init_idx - FW'(1);
      next_mem[init_idx] <= init_idx + FW'(1);
    end else begin
      if (wr_en.byte_we) byte_mem[wr_addr] <= wr_byte;
      if (wr_en.page_we) page_mem[wr_addr] <= wr_page;
      if (wr_en.prev_we) prev_mem[wr_addr] <= wr_prev;
      if (wr_en.next_we) next_mem[wr_addr] <= wr_next;
    end
    if (rd_en) begin
      rd_byte_r <= byte_mem[rd_addr];
      rd_page_r <= page_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
      rd_next_r <= next_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lru_demand_paging_engine.sv =====
// lru_demand_paging_engine: top level with access sequencer, lru list pointers and output register
// depends on lrudp_pkg, lrudp_page_table and lrudp_frame_table
//
// Demand-paged byte memory: PAGES one-byte logical pages over FRAMES physical frames
// (FRAMES must not exceed PAGES), least-recently-used replacement kept as a doubly
// linked list of frames in the frame table with head (oldest) and tail (newest)
// registers. One access is worked at a time: a hit steps through S_PAGE, S_HIT_FR, then
// S_MV_NEXT to S_MV_SELF, a miss adds S_MISS_VIC, an out-of-range address goes straight
// to S_DONE, which holds while the output is stalled and then loads the result into the
// output register; the steps are set by the one-port reads and the four single-entry link
// writes to the frame table. After reset a clearing pass over all PAGES entries loads the
// reset contents into both tables, and no input transfer is taken until it ends. The output
// register lets the next input transfer happen while a result waits.
module lru_demand_paging_engine
  import lrudp_pkg::*;
#(
  parameter int PAGES  = 32,
  parameter int FRAMES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // address[5:0], write_data[13:6], zero
  input  logic                   in_tuser,   // mode[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_data[7:0], frame[11:8], page_fault[12], zero
  output logic                   out_tuser   // status[0]
);

  localparam int PW = $clog2(PAGES);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  state_t state_r, state_nxt;

  logic              clearing_r, clearing_nxt;
  logic [PW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [FW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     tail_r, tail_nxt;

  logic              mode_r, mode_nxt;
  logic [PW-1:0]     pidx_r, pidx_nxt;
  logic [BYTE_W-1:0] wdata_r, wdata_nxt;
  logic              status_r, status_nxt;
  logic              fault_r, fault_nxt;
  logic              dirty_r, dirty_nxt;
  logic [FW-1:0]     f_r, f_nxt;
  logic [FW-1:0]     prev_r, prev_nxt;
  logic [FW-1:0]     next_r, next_nxt;
  logic [BYTE_W-1:0] ldbyte_r, ldbyte_nxt;
  logic [BYTE_W-1:0] oldbyte_r, oldbyte_nxt;
  logic [BYTE_W-1:0] rdata_r, rdata_nxt;
  logic [PW-1:0]     vpage_r, vpage_nxt;
  logic              at_head_r, at_head_nxt;
  logic              at_tail_r, at_tail_nxt;
  logic              nxt_tail_r, nxt_tail_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [BYTE_W-1:0] out_rdata_r, out_rdata_nxt;
  logic [FRAME_OUT_W-1:0] out_frame_r, out_frame_nxt;
  logic              out_fault_r, out_fault_nxt;

  logic              pt_rd_en, pt_wr_en, pt_wr_present, pt_wr_dirty;
  logic [PW-1:0]     pt_rd_addr, pt_wr_addr;
  logic [FW-1:0]     pt_wr_frame;
  logic [BYTE_W-1:0] pt_wr_byte;
  logic              pt_present, pt_dirty;
  logic [FW-1:0]     pt_frame;
  logic [BYTE_W-1:0] pt_byte;

  logic              ft_rd_en, ft_init_en;
  logic [FW-1:0]     ft_rd_addr, ft_wr_addr, ft_wr_prev, ft_wr_next;
  frame_we_t         ft_wr_en;
  logic [BYTE_W-1:0] ft_wr_byte, ft_byte;
  logic [PW-1:0]     ft_wr_page, ft_page;
  logic [FW-1:0]     ft_prev, ft_next;

  logic [ADDR_W-1:0]    in_address;
  logic [PW+ADDR_W-1:0] addr_ext;
  logic                 addr_bad;
  logic [FW+FRAME_OUT_W-1:0] f_ext;

  assign in_address = in_tdata[ADDR_W-1:0];
  assign addr_ext   = {{PW{1'b0}}, in_address};
  assign addr_bad   = int'(in_address) >= PAGES;
  assign f_ext      = {{FRAME_OUT_W{1'b0}}, f_r};
  assign ft_init_en = clearing_r && (int'(clr_cnt_r) < FRAMES);

  lrudp_page_table #(.PAGES(PAGES), .FRAMES(FRAMES)) u_page_table (
    .clk        (clk),
    .init_en    (clearing_r),
    .init_idx   (clr_cnt_r),
    .rd_en      (pt_rd_en),
    .rd_addr    (pt_rd_addr),
    .wr_en      (pt_wr_en),
    .wr_addr    (pt_wr_addr),
    .wr_present (pt_wr_present),
    .wr_dirty   (pt_wr_dirty),
    .wr_frame   (pt_wr_frame),
    .wr_byte    (pt_wr_byte),
    .rd_present (pt_present),
    .rd_dirty   (pt_dirty),
    .rd_frame   (pt_frame),
    .rd_byte    (pt_byte)
  );

  lrudp_frame_table #(.PAGES(PAGES), .FRAMES(FRAMES)) u_frame_table (
    .clk       (clk),
    .init_en   (ft_init_en),
    .init_idx  (clr_cnt_r[FW-1:0]),
    .rd_en     (ft_rd_en),
    .rd_addr   (ft_rd_addr),
    .wr_en     (ft_wr_en),
    .wr_addr   (ft_wr_addr),
    .wr_byte   (ft_wr_byte),
    .wr_page   (ft_wr_page),
    .wr_prev   (ft_wr_prev),
    .wr_next   (ft_wr_next),
    .rd_byte_r (ft_byte),
    .rd_page_r (ft_page),
    .rd_prev_r (ft_prev),
    .rd_next_r (ft_next)
  );

  always_comb begin
    state_nxt     = state_r;
    clearing_nxt  = clearing_r;
    clr_cnt_nxt   = clr_cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    mode_nxt      = mode_r;
    pidx_nxt      = pidx_r;
    wdata_nxt     = wdata_r;
    status_nxt    = status_r;
    fault_nxt     = fault_r;
    dirty_nxt     = dirty_r;
    f_nxt         = f_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    ldbyte_nxt    = ldbyte_r;
    oldbyte_nxt   = oldbyte_r;
    rdata_nxt     = rdata_r;
    vpage_nxt     = vpage_r;
    at_head_nxt   = at_head_r;
    at_tail_nxt   = at_tail_r;
    nxt_tail_nxt  = nxt_tail_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rdata_nxt  = out_rdata_r;
    out_frame_nxt  = out_frame_r;
    out_fault_nxt  = out_fault_r;

    in_tready     = 1'b0;
    pt_rd_en      = 1'b0;
    pt_rd_addr    = pidx_r;
    pt_wr_en      = 1'b0;
    pt_wr_addr    = pidx_r;
    pt_wr_present = 1'b1;
    pt_wr_dirty   = 1'b0;
    pt_wr_frame   = f_r;
    pt_wr_byte    = ldbyte_r;
    ft_rd_en      = 1'b0;
    ft_rd_addr    = f_r;
    ft_wr_en      = '0;
    ft_wr_addr    = f_r;
    ft_wr_byte    = (mode_r == MODE_WRITE) ? wdata_r : ldbyte_r;
    ft_wr_page    = pidx_r;
    ft_wr_prev    = prev_r;
    ft_wr_next    = next_r;

    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + PW'(1);
      if (clr_cnt_r == PW'(PAGES - 1)) clearing_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = !clearing_r;
        if (in_tvalid && !clearing_r) begin
          mode_nxt  = in_tuser;
          pidx_nxt  = addr_ext[PW-1:0];
          wdata_nxt = in_tdata[ADDR_W+BYTE_W-1:ADDR_W];
          fault_nxt = 1'b0;
          if (addr_bad) begin
            status_nxt = STATUS_RANGE;
            f_nxt      = '0;
            rdata_nxt  = '0;
            state_nxt  = S_DONE;
          end else begin
            status_nxt = STATUS_OK;
            pt_rd_en   = 1'b1;
            pt_rd_addr = addr_ext[PW-1:0];
            state_nxt  = S_PAGE;
          end
        end
      end
      S_PAGE: begin
        ldbyte_nxt = pt_byte;
        dirty_nxt  = pt_dirty;
        ft_rd_en   = 1'b1;
        if (pt_present) begin
          f_nxt      = pt_frame;
          ft_rd_addr = pt_frame;
          state_nxt  = S_HIT_FR;
        end else begin
          fault_nxt  = 1'b1;
          f_nxt      = head_r;
          ft_rd_addr = head_r;
          state_nxt  = S_MISS_FR;
        end
      end
      S_HIT_FR, S_MISS_FR: begin
        prev_nxt     = ft_prev;
        next_nxt     = ft_next;
        oldbyte_nxt  = ft_byte;
        vpage_nxt    = ft_page;
        at_head_nxt  = f_r == head_r;
        at_tail_nxt  = f_r == tail_r;
        nxt_tail_nxt = ft_next == tail_r;
        if (state_r == S_MISS_FR) begin
          pt_rd_en   = 1'b1;
          pt_rd_addr = ft_page;
          state_nxt  = S_MISS_VIC;
        end else begin
          state_nxt  = S_MV_NEXT;
        end
      end
      S_MISS_VIC: begin
        pt_wr_en      = 1'b1;
        pt_wr_addr    = vpage_r;
        pt_wr_present = 1'b0;
        pt_wr_dirty   = 1'b0;
        pt_wr_frame   = pt_frame;
        pt_wr_byte    = pt_dirty ? oldbyte_r : pt_byte;
        state_nxt     = S_MV_NEXT;
      end
      S_MV_NEXT: begin
        pt_wr_en    = 1'b1;
        pt_wr_dirty = fault_r ? mode_r : (dirty_r || mode_r);
        if (!at_tail_r) begin
          ft_wr_en.prev_we = 1'b1;
          ft_wr_en.next_we = nxt_tail_r;
          ft_wr_addr       = next_r;
          ft_wr_next       = f_r;
          if (at_head_r) head_nxt = next_r;
        end
        state_nxt = S_MV_PREV;
      end
      S_MV_PREV: begin
        if (!at_tail_r && !at_head_r) begin
          ft_wr_en.next_we = 1'b1;
          ft_wr_addr       = prev_r;
        end
        state_nxt = S_MV_TAIL;
      end
      S_MV_TAIL: begin
        if (!at_tail_r && !nxt_tail_r) begin
          ft_wr_en.next_we = 1'b1;
          ft_wr_addr       = tail_r;
          ft_wr_next       = f_r;
        end
        state_nxt = S_MV_SELF;
      end
      S_MV_SELF: begin
        ft_wr_en.prev_we = !at_tail_r;
        ft_wr_en.byte_we = fault_r || (mode_r == MODE_WRITE);
        ft_wr_en.page_we = fault_r;
        ft_wr_prev       = tail_r;
        tail_nxt         = f_r;
        if (mode_r == MODE_WRITE) rdata_nxt = '0;
        else rdata_nxt = fault_r ? ldbyte_r : oldbyte_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_rdata_nxt  = rdata_r;
          out_frame_nxt  = f_ext[FRAME_OUT_W-1:0];
          out_fault_nxt  = fault_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      head_r      <= '0;
      tail_r      <= FW'(FRAMES - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    pidx_r       <= pidx_nxt;
    wdata_r      <= wdata_nxt;
    status_r     <= status_nxt;
    fault_r      <= fault_nxt;
    dirty_r      <= dirty_nxt;
    f_r          <= f_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    ldbyte_r     <= ldbyte_nxt;
    oldbyte_r    <= oldbyte_nxt;
    rdata_r      <= rdata_nxt;
    vpage_r      <= vpage_nxt;
    at_head_r    <= at_head_nxt;
    at_tail_r    <= at_tail_nxt;
    nxt_tail_r   <= nxt_tail_nxt;
    out_status_r <= out_status_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_frame_r  <= out_frame_nxt;
    out_fault_r  <= out_fault_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - BYTE_W - FRAME_OUT_W - 1){1'b0}},
                       out_fault_r, out_frame_r, out_rdata_r};

`ifndef NO_ASSERTIONS
  a_list_ends_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (FRAMES > 1 && !clearing_r && state_r == S_IDLE) |-> (head_r != tail_r))
    else $error("lru head and tail coincide");

  a_hit_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HIT_FR) |-> (ft_page == pidx_r))
    else $error("hit frame not owned by requested page");

  a_victim_resident: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MISS_VIC) |-> (pt_present && vpage_r != pidx_r))
    else $error("evicted page not resident");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench for lru_demand_paging_engine: directed and random page accesses over the streams
// depends on lrudp_pkg and the rtl top level; keeps its own lru paging predictor for checking
module testbench;
  import lrudp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES       = 32;
  localparam int FRAMES      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_N    = 400;

  typedef struct packed {
    logic             mode;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } access_t;

  typedef struct packed {
    logic                   status;
    logic [BYTE_W-1:0]      rdata;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   fault;
  } access_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  lru_demand_paging_engine #(.PAGES(PAGES), .FRAMES(FRAMES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // predictor state
  logic                   resident   [PAGES];
  logic                   dirty      [PAGES];
  logic [FRAME_OUT_W-1:0] frame_of   [PAGES];
  logic [4:0]             lru_list   [FRAMES];
  logic [BYTE_W-1:0]      frame_data [FRAMES];
  logic [BYTE_W-1:0]      backing    [PAGES];

  access_t        pending_accesses[$];
  access_result_t expected_results[$];
  int             fail_count     = 0;
  int             accepted_count = 0;
  int             queued_count   = 0;
  int             cycle_count    = 0;
  int             burst_left;
  int             gap_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic access_result_t predict_access(logic mode, logic [ADDR_W-1:0] addr,
                                                    logic [BYTE_W-1:0] wdata);
    access_result_t         r;
    int                     pos;
    logic [4:0]             victim;
    logic [FRAME_OUT_W-1:0] f;
    r = '0;
    if (addr >= PAGES) begin
      r.status = STATUS_RANGE;
      return r;
    end
    if (resident[addr]) begin
      pos = 0;
      for (int k = FRAMES - 1; k >= 0; k--)
        if (lru_list[k] == addr[4:0]) pos = k;
      for (int k = pos; k + 1 < FRAMES; k++) lru_list[k] = lru_list[k + 1];
      lru_list[FRAMES - 1] = addr[4:0];
      f = frame_of[addr];
    end else begin
      victim = lru_list[0];
      r.fault = 1'b1;
      for (int k = 0; k + 1 < FRAMES; k++) lru_list[k] = lru_list[k + 1];
      lru_list[FRAMES - 1] = addr[4:0];
      f = frame_of[victim];
      if (dirty[victim]) backing[victim] = frame_data[f];
      resident[victim] = 1'b0;
      dirty[victim]    = 1'b0;
      frame_of[addr]   = f;
      frame_data[f]    = backing[addr];
      dirty[addr]      = 1'b0;
      resident[addr]   = 1'b1;
    end
    if (mode == MODE_WRITE) begin
      frame_data[f] = wdata;
      dirty[addr]   = 1'b1;
    end else begin
      r.rdata = frame_data[f];
    end
    r.status = STATUS_OK;
    r.frame  = f;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic queue_access(logic mode, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] wdata);
    access_t a;
    a.mode  = mode;
    a.addr  = addr;
    a.wdata = wdata;
    pending_accesses.push_back(a);
    queued_count++;
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() != 0 || in_tvalid || accepted_count != queued_count ||
           expected_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    access_t a;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_access(in_tuser, in_tdata[5:0], in_tdata[13:6]));
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_accesses.size() != 0) begin
          a = pending_accesses.pop_front();
          in_tdata  <= {2'b00, a.wdata, a.addr};
          in_tuser  <= a.mode;
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4: gap_left = 0;
              5:             gap_left = $urandom_range(10, 25);
              default:       gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", int'(out_tdata), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", int'(out_tuser), int'(want.status));
          if (out_tdata[7:0] !== want.rdata)
            report_mismatch("read_data", int'(out_tdata[7:0]), int'(want.rdata));
          if (out_tdata[11:8] !== want.frame)
            report_mismatch("frame", int'(out_tdata[11:8]), int'(want.frame));
          if (out_tdata[12] !== want.fault)
            report_mismatch("page_fault", int'(out_tdata[12]), int'(want.fault));
          if (out_tdata[15:13] !== 3'b000)
            report_mismatch("tdata pad", int'(out_tdata[15:13]), 0);
        end
      end
      case ((cycle_count / 97) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= (cycle_count % 5 < 2);
        default: out_tready <= (cycle_count % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_demand_paging_engine test failed");
      $finish;
    end
  end

  initial begin
    int a;
    rst_n = 1'b0;
    for (int i = 0; i < PAGES; i++) begin
      resident[i] = (i < FRAMES);
      dirty[i]    = 1'b0;
      frame_of[i] = (i < FRAMES) ? i[3:0] : '0;
      backing[i]  = '0;
    end
    for (int i = 0; i < FRAMES; i++) begin
      lru_list[i]   = i[4:0];
      frame_data[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // hits on reset mapping, writes, out of range, misses, dirty write-back
    queue_access(MODE_READ, 6'd0, 8'h3c);
    queue_access(MODE_WRITE, 6'd0, 8'hff);
    queue_access(MODE_READ, 6'd0, 8'h00);
    queue_access(MODE_WRITE, 6'd15, 8'h00);
    queue_access(MODE_WRITE, 6'd63, 8'hff);
    queue_access(MODE_READ, 6'd32, 8'ha5);
    queue_access(MODE_READ, 6'd16, 8'hc3);
    queue_access(MODE_WRITE, 6'd31, 8'h5a);
    queue_access(MODE_READ, 6'd31, 8'h00);
    for (int p = 17; p <= 30; p++) queue_access(MODE_READ, p[5:0], 8'h00);
    queue_access(MODE_READ, 6'd0, 8'hff);

    // sender holds off until the block has drained
    wait_idle();

    for (int n = 0; n < RANDOM_N; n++) begin
      case ($urandom_range(0, 9))
        0:       a = $urandom_range(32, 63);
        1, 2, 3: a = $urandom_range(0, 31);
        default: a = $urandom_range(0, 17);
      endcase
      queue_access(1'($urandom_range(0, 1)), a[5:0], 8'($urandom_range(0, 255)));
      if (n == RANDOM_N / 2) wait_idle();
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("lru_demand_paging_engine test passed");
    end else begin
      $display("lru_demand_paging_engine test failed");
    end
    $finish;
  end

endmodule
